// File: rtl/asr_pkg.sv
// asr_pkg: shared constants for the aspect-scaled resolution block
// no dependencies; imported by asr_align and aspect_scaled_resolution
`default_nettype none
package asr_pkg;
	localparam int STEP_W   = 10;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_STEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIM    = 1'b1;
endpackage
`default_nettype wire

// File: rtl/aspect_scaled_resolution.sv
// Target frame size for a scaler: clamps the requested height to the source,
// aligns it to align_step, clamps to max_dimension, derives the width from the
// source aspect ratio and aligns it; if the width is too large, it clamps it and
// derives the height again, aligned as well. Fully pipelined: one item per cycle
// unless the pipe holds, through the two ratio dividers (2*DIM_BITS stages each),
// the three alignment units (DIM_BITS+2 stages each) and four plain register
// stages. The whole pipe advances together; it holds while a result waits with
// out_stall high.
// Depends on asr_pkg, asr_align and asr_div.
`default_nettype none
module aspect_scaled_resolution #(
	parameter int DIM_BITS = 14,
	localparam int CFG_W = (DIM_BITS > asr_pkg::STEP_W) ? DIM_BITS : asr_pkg::STEP_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [asr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [DIM_BITS-1:0]           source_width,
	input  wire logic [DIM_BITS-1:0]           source_height,
	input  wire logic [DIM_BITS-1:0]           requested_height,
	input  wire logic                          disabled,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [DIM_BITS-1:0]                out_width,
	output logic [DIM_BITS-1:0]                out_height,
	output logic                               valid_res
);
	import asr_pkg::*;

	localparam int W = DIM_BITS;
	localparam logic [W-1:0] LIM_RST = (1920 > (1 << W) - 1) ? '1 : W'(1920);

	logic signed [STEP_W-1:0] step_q;
	logic [W-1:0]             lim_q;
	logic                     en;

	// stage 1: input capture
	logic         v_s1, kill_s1;
	logic [W-1:0] sw_s1, sh_s1, h_s1;
	// align 1
	logic           a1_v;
	logic [W-1:0]   a1_h;
	logic [2*W:0]   a1_side;
	// stage 2: clamp height, width product
	logic           v_s2;
	logic [2*W-1:0] prod_s2;
	logic [3*W:0]   side_s2;
	logic [W-1:0]   hc;
	// ratio divider 1 and align 2
	logic           d1_v;
	logic [2*W-1:0] d1_q;
	logic [3*W:0]   d1_side;
	logic           a2_v;
	logic [W-1:0]   a2_w;
	logic [3*W:0]   a2_side;
	// stage 3: width clamp, height recompute product
	logic           v_s3;
	logic [2*W-1:0] prod_s3;
	logic [W-1:0]   den_s3;
	logic [2*W+1:0] side_s3;
	logic           over;
	// ratio divider 2 and align 3
	logic           d2_v;
	logic [2*W-1:0] d2_q;
	logic [2*W+1:0] d2_side;
	logic           a3_v;
	logic [W-1:0]   a3_h;
	logic [2*W+1:0] a3_side;
	// output register
	logic           ov_q, vr_q;
	logic [W-1:0]   ow_q, oh_q;
	logic           f_kill, f_rec;
	logic [W-1:0]   f_h, f_w, f_hsel;

	assign en       = !ov_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			lim_q  <= LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALIGN_STEP: step_q <= cfg_data[STEP_W-1:0];
				CFG_MAX_DIM:    lim_q  <= cfg_data[W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kill_s1 <= disabled || source_width == '0 || source_height == '0;
			sw_s1   <= source_width;
			sh_s1   <= source_height;
			h_s1    <= (requested_height < source_height) ? requested_height : source_height;
		end
	end

	asr_align #(.VW(W), .SW(2*W+1)) u_align_h (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s1),
		.value  (h_s1),
		.step   (step_q),
		.side   ({kill_s1, sw_s1, sh_s1}),
		.out_v  (a1_v),
		.result (a1_h),
		.side_o (a1_side)
	);

	// stage 2
	assign hc = (a1_h > lim_q) ? lim_q : a1_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= a1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= hc * a1_side[2*W-1:W];
			side_s2 <= {a1_side, hc};
		end
	end

	// side_s2: kill, sw, sh, h
	asr_div #(.NW(2*W), .DW(W), .SW(3*W+1)) u_div_w (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.num    (prod_s2),
		.den    (side_s2[2*W-1:W]),
		.side   (side_s2),
		.out_v  (d1_v),
		.quo    (d1_q),
		.side_o (d1_side)
	);

	asr_align #(.VW(W), .SW(3*W+1)) u_align_w (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (d1_v),
		.value  ((|d1_q[2*W-1:W]) ? '1 : d1_q[W-1:0]),
		.step   (step_q),
		.side   (d1_side),
		.out_v  (a2_v),
		.result (a2_w),
		.side_o (a2_side)
	);

	// stage 3: a too-wide result pins width and derives height again
	assign over = a2_w > lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= a2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= lim_q * a2_side[2*W-1:W];
			den_s3  <= a2_side[3*W-1:2*W];
			side_s3 <= {a2_side[3*W], over, a2_side[W-1:0], over ? lim_q : a2_w};
		end
	end

	// side_s3: kill, recompute, h, w
	asr_div #(.NW(2*W), .DW(W), .SW(2*W+2)) u_div_h (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s3),
		.num    (prod_s3),
		.den    (den_s3),
		.side   (side_s3),
		.out_v  (d2_v),
		.quo    (d2_q),
		.side_o (d2_side)
	);

	asr_align #(.VW(W), .SW(2*W+2)) u_align_h2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (d2_v),
		.value  ((|d2_q[2*W-1:W]) ? '1 : d2_q[W-1:0]),
		.step   (step_q),
		.side   (d2_side),
		.out_v  (a3_v),
		.result (a3_h),
		.side_o (a3_side)
	);

	assign f_kill = a3_side[2*W+1];
	assign f_rec  = a3_side[2*W];
	assign f_h    = a3_side[2*W-1:W];
	assign f_w    = a3_side[W-1:0];
	assign f_hsel = f_rec ? a3_h : f_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= a3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ow_q <= f_kill ? '0 : f_w;
			oh_q <= f_kill ? '0 : f_hsel;
			vr_q <= !f_kill && f_hsel != '0;
		end
	end

	assign out_valid  = ov_q;
	assign out_width  = ow_q;
	assign out_height = oh_q;
	assign valid_res  = vr_q;

	a_valid_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> out_height != '0)
		else $error("valid result with zero height");

	// a recomputed height of zero keeps the pinned width
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> out_height == '0)
		else $error("invalid result carries a nonzero height");

	a_width_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_width <= lim_q)
		else $error("width above max_dimension");
endmodule
`default_nettype wire

// File: rtl/asr_div.sv
// asr_div: pipelined restoring divider, one quotient bit per stage
// no package dependency; used by asr_align and the top level
`default_nettype none
module asr_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_v,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_v,
	output logic [NW-1:0]      quo,
	output logic [SW-1:0]      side_o
);
	logic          v_s    [NW+1];
	logic [DW-1:0] rem_s  [NW+1];
	logic [NW-1:0] num_s  [NW+1];
	logic [DW-1:0] den_s  [NW+1];
	logic [SW-1:0] side_s [NW+1];

	assign v_s[0]    = in_v;
	assign rem_s[0]  = '0;
	assign num_s[0]  = num;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] t;
		logic        ge;
		// shift in next dividend bit, subtract when it fits
		assign t  = {rem_s[k], num_s[k][NW-1]};
		assign ge = t >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? DW'(t - {1'b0, den_s[k]}) : t[DW-1:0];
				num_s[k+1]  <= {num_s[k][NW-2:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_v  = v_s[NW];
	assign quo    = num_s[NW];
	assign side_o = side_s[NW];
endmodule
`default_nettype wire

// File: rtl/asr_align.sv
// asr_align: aligns a size to a signed step (up, down or none), saturating
// depends on asr_pkg and asr_div
`default_nettype none
module asr_align #(
	parameter int VW = 14,
	parameter int SW = 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_v,
	input  wire logic [VW-1:0]                    value,
	input  wire logic signed [asr_pkg::STEP_W-1:0] step,
	input  wire logic [SW-1:0]                    side,
	output logic                                  out_v,
	output logic [VW-1:0]                         result,
	output logic [SW-1:0]                         side_o
);
	import asr_pkg::*;

	logic [STEP_W-1:0]    mag;
	logic [VW:0]          sum;
	logic                 dv;
	logic [VW:0]          dq;
	logic [SW-1:0]        dside;
	logic                 v_s1;
	logic [VW+STEP_W:0]   prod_s1;
	logic [SW-1:0]        side_s1;

	// zero step divides by one, which leaves the value as it is
	always_comb begin
		if (step == '0) begin
			mag = STEP_W'(1);
		end else if (step < 0) begin
			mag = STEP_W'(-step);
		end else begin
			mag = STEP_W'(step);
		end
		sum = {1'b0, value} + ((step > 0) ? (VW+1)'(mag - STEP_W'(1)) : '0);
	end

	asr_div #(.NW(VW + 1), .DW(STEP_W), .SW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_v),
		.num    (sum),
		.den    (mag),
		.side   (side),
		.out_v  (dv),
		.quo    (dq),
		.side_o (dside)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= dq * mag;
			side_s1 <= dside;
		end
	end

	assign out_v  = v_s1;
	assign result = (|prod_s1[VW+STEP_W:VW]) ? '1 : prod_s1[VW-1:0];
	assign side_o = side_s1;
endmodule
`default_nettype wire
